// ===== rtl/core/tbss_pkg.sv =====
// ----------------------------------------------------------------------------
// tbss_pkg: shared types and constants of the two-button speed stepper
// widths, register indexes, reset values and the debounce status bundle
// ----------------------------------------------------------------------------
package tbss_pkg;

  localparam int unsigned CountW     = 8;
  localparam int unsigned SpeedW     = 16;
  localparam int unsigned SetpointW  = 17;
  localparam int unsigned StepW      = 3;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 16;
  localparam int unsigned InDataW    = 8;
  localparam int unsigned OutDataW   = 24;

  // number of speed step registers on the configuration port
  localparam int unsigned NumStepRegs = 5;
  // default number of steps in use
  localparam int unsigned NumStepsDef = 5;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgDebounce = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgStep0    = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgStep1    = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgStep2    = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgStep3    = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgStep4    = 3'd5;

  // reset values of the configuration registers
  localparam logic [CountW-1:0] DebounceRst = 8'd5;
  localparam logic [SpeedW-1:0] Step0Rst    = 16'd3000;
  localparam logic [SpeedW-1:0] Step1Rst    = 16'd4000;
  localparam logic [SpeedW-1:0] Step2Rst    = 16'd5000;
  localparam logic [SpeedW-1:0] Step3Rst    = 16'd6000;
  localparam logic [SpeedW-1:0] Step4Rst    = 16'd7000;

  // bit positions in the output tdata
  localparam int unsigned OutUpdateBit = 17;
  localparam int unsigned OutStartBit  = 18;
  localparam int unsigned OutStopBit   = 19;

  typedef struct packed {
    logic press;  // new press confirmed this tick
    logic held;   // confirmed held state before this tick
  } deb_status_t;

endpackage

// ===== rtl/core/tbss_debounce.sv =====
// ----------------------------------------------------------------------------
// tbss_debounce: counter debounce of one active-low button
// press and release are both confirmed after limit_i ticks at the new level
// ----------------------------------------------------------------------------
module tbss_debounce (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              level_i,
  input  logic [tbss_pkg::CountW-1:0]       limit_i,
  output tbss_pkg::deb_status_t             status_o
);

  logic [tbss_pkg::CountW-1:0] count_q, count_d, count_inc;
  logic                        held_q, held_d;
  logic                        toward_change;
  logic                        confirm;

  always_comb begin
    toward_change = held_q ? level_i : ~level_i;
    count_inc     = toward_change ? count_q + 1'b1 : '0;
    confirm       = (count_inc >= limit_i);
    count_d       = confirm ? '0 : count_inc;
    held_d        = confirm ? ~held_q : held_q;
  end

  assign status_o.press = confirm & ~held_q;
  assign status_o.held  = held_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      held_q  <= 1'b0;
    end else if (en_i) begin
      count_q <= count_d;
      held_q  <= held_d;
    end
  end

endmodule

// ===== rtl/core/two_button_speed_stepper_unit.sv =====
// ----------------------------------------------------------------------------
// two_button_speed_stepper_unit: two-button speed step selector
// path: input transfer into the input reg, then tick logic into the result reg
// throughput: one tick per cycle unless the result stream stalls, set by the
//   single pass of the tick logic
// reset: async active low; counters, held states, step and direction cleared,
//   configuration back to 5 ticks and 3000..7000 rpm, both stages empty
// ----------------------------------------------------------------------------
module two_button_speed_stepper_unit #(
  parameter int unsigned NUM_STEPS = tbss_pkg::NumStepsDef  // steps in use, 2..5
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // input tick stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [0] level_a, [1] level_b, [2] motor_running, [7:3] zero
  input  logic [tbss_pkg::InDataW-1:0]      s_axis_tdata,
  // result stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [16:0] setpoint_rpm, [17] setpoint_update, [18] start_request,
  // [19] stop_request, [23:20] zero
  output logic [tbss_pkg::OutDataW-1:0]     m_axis_tdata,
  // configuration write port
  input  logic                              cfg_we_i,
  input  logic [tbss_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [tbss_pkg::CfgDataW-1:0]     cfg_wdata_i
);

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_POS  = 2'd1,
    DIR_NEG  = 2'd2
  } dir_e;

  localparam logic [tbss_pkg::StepW-1:0] LastStep = tbss_pkg::StepW'(NUM_STEPS - 1);

  // configuration registers
  logic [tbss_pkg::CountW-1:0] debounce_q;
  logic [tbss_pkg::SpeedW-1:0] speed_q [tbss_pkg::NumStepRegs];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= tbss_pkg::DebounceRst;
      speed_q[0] <= tbss_pkg::Step0Rst;
      speed_q[1] <= tbss_pkg::Step1Rst;
      speed_q[2] <= tbss_pkg::Step2Rst;
      speed_q[3] <= tbss_pkg::Step3Rst;
      speed_q[4] <= tbss_pkg::Step4Rst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tbss_pkg::CfgDebounce: debounce_q <= cfg_wdata_i[tbss_pkg::CountW-1:0];
        tbss_pkg::CfgStep0:    speed_q[0] <= cfg_wdata_i;
        tbss_pkg::CfgStep1:    speed_q[1] <= cfg_wdata_i;
        tbss_pkg::CfgStep2:    speed_q[2] <= cfg_wdata_i;
        tbss_pkg::CfgStep3:    speed_q[3] <= cfg_wdata_i;
        tbss_pkg::CfgStep4:    speed_q[4] <= cfg_wdata_i;
        default: ;  // writes past the last register are dropped
      endcase
    end
  end

  // a zero debounce setting behaves like one tick
  logic [tbss_pkg::CountW-1:0] limit;
  assign limit = (debounce_q == '0) ? tbss_pkg::CountW'(1) : debounce_q;

  // --------------------------------------------------------------------------
  // handshake: input register feeds the tick logic, result register on output
  // --------------------------------------------------------------------------
  logic       in_valid_q;
  logic [2:0] in_data_q;   // {motor_running, level_b, level_a}
  logic       out_valid_q;
  logic       out_free;
  logic       advance;     // tick logic runs and result register loads

  assign out_free      = ~out_valid_q | m_axis_tready;
  assign advance       = in_valid_q & out_free;
  assign s_axis_tready = ~in_valid_q | advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_data_q <= s_axis_tdata[2:0];
    end
  end

  // --------------------------------------------------------------------------
  // button debounce, state moves only when a tick is processed
  // --------------------------------------------------------------------------
  tbss_pkg::deb_status_t deb_a, deb_b;

  tbss_debounce u_deb_a (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (advance),
    .level_i  (in_data_q[0]),
    .limit_i  (limit),
    .status_o (deb_a)
  );

  tbss_debounce u_deb_b (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (advance),
    .level_i  (in_data_q[1]),
    .limit_i  (limit),
    .status_o (deb_b)
  );

  // --------------------------------------------------------------------------
  // tick logic: A handled first, then B
  // --------------------------------------------------------------------------
  logic [tbss_pkg::StepW-1:0]     step_q, step_d;
  dir_e                           dir_q, dir_d, dir_a;
  logic                           running;
  logic                           start, stop, update;
  logic [tbss_pkg::SpeedW-1:0]    rpm;
  logic [tbss_pkg::SetpointW-1:0] setpoint;

  assign running = in_data_q[2];

  always_comb begin
    step_d   = step_q;
    dir_a    = dir_q;
    start    = 1'b0;
    update   = 1'b0;
    setpoint = '0;
    if (deb_a.press) begin
      update = 1'b1;
      if (!running) begin
        // start: first step, direction from B held before this tick
        step_d = '0;
        dir_a  = deb_b.held ? DIR_POS : DIR_NEG;
        start  = 1'b1;
      end else begin
        step_d = (step_q >= LastStep) ? '0 : step_q + 1'b1;
      end
    end
    rpm = speed_q[step_d];
    if (deb_a.press) begin
      case (dir_a)
        DIR_POS: setpoint = {1'b0, rpm};
        DIR_NEG: setpoint = -{1'b0, rpm};
        default: setpoint = '0;  // running without a direction
      endcase
    end
    // B press stops a running or just started motor
    stop  = deb_b.press & (running | start);
    dir_d = stop ? DIR_NONE : dir_a;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      dir_q  <= DIR_NONE;
    end else if (advance) begin
      step_q <= step_d;
      dir_q  <= dir_d;
    end
  end

  // --------------------------------------------------------------------------
  // result register
  // --------------------------------------------------------------------------
  logic [tbss_pkg::OutDataW-1:0] out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= {4'b0000, stop, start, update, setpoint};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ===== rtl/core/tbss_checker.sv =====
// ----------------------------------------------------------------------------
// tbss_checker: port-level checks of the speed stepper
// result stream hold rules and consistency of the result flags
// ----------------------------------------------------------------------------
module tbss_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic [tbss_pkg::OutDataW-1:0] m_axis_tdata
);

  // a stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // a start always comes with a new setpoint
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[tbss_pkg::OutStartBit]
      |-> m_axis_tdata[tbss_pkg::OutUpdateBit])
    else $error("start without setpoint update");

  // no setpoint update means a zero setpoint
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[tbss_pkg::OutUpdateBit]
      |-> (m_axis_tdata[tbss_pkg::SetpointW-1:0] == '0))
    else $error("setpoint nonzero without update");

endmodule

bind two_button_speed_stepper_unit tbss_checker u_tbss_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== dv/two_button_speed_stepper_unit_tb.sv =====
// ----------------------------------------------------------------------------
// two_button_speed_stepper_unit_tb: self-checking bench of the speed stepper
// drives button ticks as stream transfers, predicts debounce, start, step
// advance, setpoint sign and stop for every tick, and compares each result
// transfer field by field; configuration changes only while the block is idle
// ----------------------------------------------------------------------------
module two_button_speed_stepper_unit_tb;

  localparam int unsigned NumSteps   = tbss_pkg::NumStepsDef;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned HoldCycles = 300;

  typedef enum logic [1:0] {SpinNone, SpinFwd, SpinRev} spin_dir_e;

  // matches m_axis_tdata[19:0] from the highest bit down
  typedef struct packed {
    logic                           stop;
    logic                           start;
    logic                           update;
    logic [tbss_pkg::SetpointW-1:0] setpoint;
  } tick_result_t;

  typedef logic [tbss_pkg::SpeedW-1:0] speed_set_t [tbss_pkg::NumStepRegs];

  localparam logic [tbss_pkg::CfgIdxW-1:0] StepRegs [tbss_pkg::NumStepRegs] =
    '{tbss_pkg::CfgStep0, tbss_pkg::CfgStep1, tbss_pkg::CfgStep2,
      tbss_pkg::CfgStep3, tbss_pkg::CfgStep4};

  // predicts one result per tick and holds them until the block returns them
  class speed_step_scoreboard;
    logic [tbss_pkg::CountW-1:0] deb_ticks;
    logic [tbss_pkg::SpeedW-1:0] speeds [tbss_pkg::NumStepRegs];
    logic [tbss_pkg::CountW-1:0] cnt [2];
    logic                        held [2];
    logic [tbss_pkg::StepW-1:0]  step;
    spin_dir_e                   dir;
    tick_result_t                expected [$];
    int unsigned                 errors;

    function new();
      deb_ticks = tbss_pkg::DebounceRst;
      speeds    = '{tbss_pkg::Step0Rst, tbss_pkg::Step1Rst, tbss_pkg::Step2Rst,
                    tbss_pkg::Step3Rst, tbss_pkg::Step4Rst};
      cnt       = '{'0, '0};
      held      = '{1'b0, 1'b0};
      step      = '0;
      dir       = SpinNone;
      errors    = 0;
    endfunction

    function void set_reg(logic [tbss_pkg::CfgIdxW-1:0] idx,
                          logic [tbss_pkg::CfgDataW-1:0] val);
      if (idx == tbss_pkg::CfgDebounce) deb_ticks = val[tbss_pkg::CountW-1:0];
      else speeds[idx - tbss_pkg::CfgStep0] = val[tbss_pkg::SpeedW-1:0];
    endfunction

    function int unsigned pending();
      return expected.size();
    endfunction

    // button 0 is A, 1 is B; true on a newly confirmed press
    function bit confirm_press(int unsigned btn, logic level);
      logic [tbss_pkg::CountW-1:0] limit;
      logic                        toward;
      limit  = (deb_ticks == '0) ? tbss_pkg::CountW'(1) : deb_ticks;
      toward = held[btn] ? level : !level;
      cnt[btn] = toward ? cnt[btn] + 1'b1 : '0;
      if (cnt[btn] >= limit) begin
        cnt[btn]  = '0;
        held[btn] = !held[btn];
        return held[btn];
      end
      return 1'b0;
    endfunction

    function void note_tick(logic lvl_a, logic lvl_b, logic running);
      logic                           b_before;
      logic [tbss_pkg::SetpointW-1:0] rpm;
      tick_result_t                   res;
      b_before = held[1];
      res      = '0;
      if (confirm_press(0, lvl_a)) begin
        if (!running) begin
          step      = '0;
          dir       = b_before ? SpinFwd : SpinRev;
          res.start = 1'b1;
        end else begin
          step = (step >= tbss_pkg::StepW'(NumSteps - 1)) ? '0 : step + 1'b1;
        end
        rpm = {1'b0, speeds[step]};
        case (dir)
          SpinFwd: res.setpoint = rpm;
          SpinRev: res.setpoint = -rpm;
          default: res.setpoint = '0;
        endcase
        res.update = 1'b1;
      end
      if (confirm_press(1, lvl_b) && (running || res.start)) begin
        dir      = SpinNone;
        res.stop = 1'b1;
      end
      expected.push_back(res);
    endfunction

    function void check_result(logic [tbss_pkg::OutDataW-1:0] data);
      tick_result_t want;
      tick_result_t got;
      if (expected.size() == 0) begin
        $error("result transfer with nothing expected: tdata %h", data);
        errors++;
        return;
      end
      want = expected.pop_front();
      got  = data[$bits(tick_result_t)-1:0];
      if (got.setpoint !== want.setpoint) begin
        $error("setpoint_rpm: expected %0d, got %0d",
               $signed(want.setpoint), $signed(got.setpoint));
        errors++;
      end
      if (got.update !== want.update) begin
        $error("setpoint_update: expected %0b, got %0b", want.update, got.update);
        errors++;
      end
      if (got.start !== want.start) begin
        $error("start_request: expected %0b, got %0b", want.start, got.start);
        errors++;
      end
      if (got.stop !== want.stop) begin
        $error("stop_request: expected %0b, got %0b", want.stop, got.stop);
        errors++;
      end
    endfunction
  endclass

  logic                           clk_i         = 1'b0;
  logic                           rst_ni        = 1'b0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [tbss_pkg::InDataW-1:0]   s_axis_tdata  = '0;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [tbss_pkg::OutDataW-1:0]  m_axis_tdata;
  logic                           cfg_we_i      = 1'b0;
  logic [tbss_pkg::CfgIdxW-1:0]   cfg_idx_i     = '0;
  logic [tbss_pkg::CfgDataW-1:0]  cfg_wdata_i   = '0;

  speed_step_scoreboard sb = new();
  int unsigned          cyc     = 0;
  bit                   tx_calm = 1'b0;  // sender never idles while set

  two_button_speed_stepper_unit #(
    .NUM_STEPS(NumSteps)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always #10 clk_i = ~clk_i;

  // watchdog on the whole run
  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc == CycleLimit) begin
      $display("two_button_speed_stepper_unit verification failed");
      $finish;
    end
  end

  // result side: handshakes are sampled at the edge, so values read here are
  // the ones the block saw at that edge; ready changes by nonblocking update
  initial begin : result_side
    int unsigned taken;
    int unsigned hold_left;
    bit          held_once;
    taken     = 0;
    hold_left = 0;
    held_once = 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_result(m_axis_tdata);
        taken++;
      end
      // one long hold-off so the pipeline fills and back-pressures the input
      if (!held_once && taken == 600) begin
        held_once = 1'b1;
        hold_left = HoldCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (taken >= 900 && taken < 1300) begin
        m_axis_tready <= 1'b1;  // stretch with no stalls
      end else begin
        m_axis_tready <= ($urandom_range(99) >= 23);
      end
    end
  end

  // one tick transfer; random gaps ahead of it unless the sender is calm
  task automatic send_tick(input logic lvl_a, input logic lvl_b, input logic running);
    while (!tx_calm && $urandom_range(99) < 23) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(tbss_pkg::InDataW-3){1'b0}}, running, lvl_b, lvl_a};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_tick(lvl_a, lvl_b, running);
  endtask

  // stop offering and wait for every expected result to come back
  task automatic wait_results_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  // all registers are rewritten while the block is idle
  task automatic apply_setting(input logic [tbss_pkg::CountW-1:0] deb,
                               input speed_set_t speeds);
    int unsigned i;
    wait_results_drained();
    repeat (4) @(posedge clk_i);  // pipeline latency margin
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= tbss_pkg::CfgDebounce;
    cfg_wdata_i <= tbss_pkg::CfgDataW'(deb);
    @(posedge clk_i);
    sb.set_reg(tbss_pkg::CfgDebounce, tbss_pkg::CfgDataW'(deb));
    for (i = 0; i < tbss_pkg::NumStepRegs; i++) begin
      cfg_idx_i   <= StepRegs[i];
      cfg_wdata_i <= speeds[i];
      @(posedge clk_i);
      sb.set_reg(StepRegs[i], speeds[i]);
    end
    cfg_we_i <= 1'b0;
  endtask

  function automatic speed_set_t random_speeds();
    speed_set_t s;
    for (int i = 0; i < tbss_pkg::NumStepRegs; i++) begin
      s[i] = tbss_pkg::SpeedW'($urandom_range(65535));
    end
    return s;
  endfunction

  // mostly steady button levels held around the debounce length, some noise
  task automatic run_random(input int unsigned n_items);
    int unsigned sent;
    int unsigned span;
    int unsigned deb;
    logic        lvl_a;
    logic        lvl_b;
    logic        running;
    sent = 0;
    deb  = 32'(sb.deb_ticks);
    while (sent < n_items) begin
      if ($urandom_range(99) < 15) begin
        send_tick(1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)));
        sent++;
      end else begin
        lvl_a   = 1'($urandom_range(1));
        lvl_b   = 1'($urandom_range(1));
        running = 1'($urandom_range(1));
        span    = $urandom_range(1, deb + deb / 2 + 2);
        for (int k = 0; k < span && sent < n_items; k++) begin
          if ($urandom_range(99) < 8) running = !running;
          send_tick(lvl_a, lvl_b, running);
          sent++;
        end
      end
    end
  endtask

  // with debounce 0 (acting as 1) every level change confirms at once
  task automatic run_directed();
    send_tick(1'b1, 1'b1, 1'b0);
    send_tick(1'b0, 1'b1, 1'b0);  // start with B released: reverse
    send_tick(1'b0, 1'b1, 1'b1);
    repeat (NumSteps) begin       // advance through every step and wrap
      send_tick(1'b1, 1'b1, 1'b1);
      send_tick(1'b0, 1'b1, 1'b1);
    end
    send_tick(1'b1, 1'b0, 1'b1);  // B press while running: stop
    send_tick(1'b0, 1'b0, 1'b1);  // A press running with no direction
    send_tick(1'b1, 1'b0, 1'b0);
    send_tick(1'b0, 1'b0, 1'b0);  // start with B already held: forward
    send_tick(1'b1, 1'b1, 1'b0);
    send_tick(1'b0, 1'b0, 1'b0);  // start and stop on the same tick
    send_tick(1'b1, 1'b1, 1'b1);
  endtask

  initial begin : stimulus
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    apply_setting(8'd0, '{16'hFFFF, 16'd0, 16'd1, 16'h8000, 16'hFFFE});
    run_directed();

    apply_setting(8'd1, random_speeds());
    run_random(300);

    // receiver hold-off lands in this phase
    apply_setting(8'd3, '{16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0});
    run_random(350);

    apply_setting(tbss_pkg::DebounceRst,
                  '{tbss_pkg::Step0Rst, tbss_pkg::Step1Rst, tbss_pkg::Step2Rst,
                    tbss_pkg::Step3Rst, tbss_pkg::Step4Rst});
    tx_calm = 1'b1;
    run_random(300);
    tx_calm = 1'b0;

    apply_setting(8'd2, random_speeds());
    run_random(150);
    wait_results_drained();
    run_random(150);

    apply_setting(8'd255, random_speeds());
    run_random(400);

    apply_setting(8'd1, '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
    run_random(100);

    wait_results_drained();
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("two_button_speed_stepper_unit verification clean");
    end else begin
      $display("two_button_speed_stepper_unit verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/tbss_pkg.sv
rtl/core/tbss_debounce.sv
rtl/core/two_button_speed_stepper_unit.sv
rtl/core/tbss_checker.sv
dv/two_button_speed_stepper_unit_tb.sv
